FILE: rtl/mafh_pkg.sv
// Shared constants, tables and lookup functions for the MPEG audio frame
// header tracker. Used by every module of the block; depends on nothing.
package mafh_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 32;

   localparam int ALU_W     = 27;
   localparam int QUOT_W    = 11;
   localparam int DIV_STEPS = 11;
   localparam int SIZE_W    = 11;
   localparam int MDB_W     = 9;

   localparam logic [11:0] SYNC_WORD = 12'hFFF;

   localparam logic [1:0] LAYER_CODE_NONE = 2'd0;
   localparam logic [1:0] LAYER_CODE_III  = 2'd1;
   localparam logic [1:0] LAYER_CODE_II   = 2'd2;
   localparam logic [1:0] LAYER_CODE_I    = 2'd3;

   localparam logic [1:0] MODE_SINGLE    = 2'd3;
   localparam logic [1:0] RATE_RESERVED  = 2'd3;
   localparam logic [1:0] EMPH_RESERVED  = 2'd2;
   localparam logic [3:0] BRI_FREE       = 4'd0;
   localparam logic [3:0] BRI_BAD        = 4'd15;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_CHAN_CHANGE = 2'd1;
   localparam logic [1:0] STATUS_BAD_HEADER  = 2'd2;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

   localparam logic [17:0] SLOT_FACTOR_I  = 18'd12000;
   localparam logic [17:0] SLOT_FACTOR_II = 18'd144000;

   localparam logic [10:0] SAMPLES_I    = 11'd384;
   localparam logic [10:0] SAMPLES_FULL = 11'd1152;
   localparam logic [10:0] SAMPLES_HALF = 11'd576;

   localparam logic [5:0] COUNT_MAX = 6'd63;

   localparam logic [15:0] RATE_TABLE [2][4] = '{
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd44100, 16'd48000, 16'd32000, 16'd0}
   };

   localparam logic [8:0] KBPS_TABLE [2][3][16] = '{
      '{
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
      },
      '{
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
         '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
      }
   };

   function automatic logic [8:0] kbps_lookup(input logic ver, input logic [1:0] layer,
                                               input logic [3:0] bri);
      logic [8:0] result;
      result = 9'd0;
      unique case (layer)
         LAYER_CODE_III: result = KBPS_TABLE[ver][0][bri];
         LAYER_CODE_II:  result = KBPS_TABLE[ver][1][bri];
         LAYER_CODE_I:   result = KBPS_TABLE[ver][2][bri];
         default:        result = 9'd0;
      endcase
      return result;
   endfunction

   function automatic logic [15:0] rate_lookup(input logic ver, input logic [1:0] fsi);
      return RATE_TABLE[ver][fsi];
   endfunction

endpackage

FILE: rtl/mafh_alu.sv
// Shared subtract and compare unit of the frame header tracker.
// Serves the slot division, the main-data size and the history walk.
// Depends on mafh_pkg.
module mafh_alu (
   input  logic [mafh_pkg::ALU_W-1:0] op_a,
   input  logic [mafh_pkg::ALU_W-1:0] op_b,
   output logic [mafh_pkg::ALU_W-1:0] diff,
   output logic                       borrow
);

   assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

FILE: rtl/mafh_history.sv
// Circular history of Layer III main-data sizes, newest entry at index 0.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on mafh_pkg.
module mafh_history #(
   parameter int HISTORY_DEPTH = mafh_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [AW-1:0]                rd_idx,
   output logic [mafh_pkg::SIZE_W-1:0]  rd_data,
   input  logic                         push,
   input  logic [mafh_pkg::SIZE_W-1:0]  push_data
);

   localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);

   logic [mafh_pkg::SIZE_W-1:0] mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0]    valid_ff;
   logic [AW-1:0]               head_ff;
   logic [AW-1:0]               head_in;
   logic [AW:0]                 rsum;
   logic [AW:0]                 raddr;
   logic [mafh_pkg::SIZE_W-1:0] rd_mem_ff;
   logic                        rd_valid_ff;

   assign head_in = (head_ff == '0) ? AW'(HISTORY_DEPTH - 1) : head_ff - 1'b1;
   assign rsum    = {1'b0, head_ff} + {1'b0, rd_idx};
   assign raddr   = (rsum >= DEPTH_W) ? rsum - DEPTH_W : rsum;
   assign rd_data = rd_valid_ff ? rd_mem_ff : '0;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[head_in] <= push_data;
      end
      rd_mem_ff <= mem[raddr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         head_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[raddr[AW-1:0]];
         if (push) begin
            valid_ff[head_in] <= 1'b1;
            head_ff           <= head_in;
         end
      end
   end

endmodule

FILE: rtl/mpeg_audio_frame_header_tracker_core.sv
// Top level of the MPEG-1/2 audio frame header tracker: sequencer, state and
// output register. Depends on mafh_pkg, mafh_alu and mafh_history.
//
// Use: one request transfer carries a frame's 32-bit header and its first two
// side-info bytes; one response transfer returns status, frame length,
// samples per frame, sample rate, channel count, Layer III pre-roll and the
// decode timestamp. req_stall is high while a frame is being processed.
// Steps: a bad or refused header goes from the header check straight to the
// final step, which writes the response and returns to idle for the next request.
// A good header runs an 11-step restoring division of the slot count on the
// shared subtractor, a step for the main-data size, and for Layer III with
// a nonzero reservoir back pointer a walk over the size history at one entry
// per cycle, over up to HISTORY_DEPTH entries, before the final step.
// The result sits in an output register; the next request is taken while it
// waits. If rsp_stall holds the previous result, the sequencer waits in its
// final step and nothing is lost. Reset clears the reference, timestamp,
// dependency count and all history entries at once; no clearing pass.
module mpeg_audio_frame_header_tracker_core #(
   parameter int HISTORY_DEPTH = mafh_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_header_word,
   input  logic [15:0] req_side_info_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_frame_bytes,
   output logic [10:0] rsp_samples_per_frame,
   output logic [15:0] rsp_sample_rate_hz,
   output logic [1:0]  rsp_channel_count,
   output logic [5:0]  rsp_preroll_frames,
   output logic [47:0] rsp_decode_time
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_SIZE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type                          state_ff;
   logic [31:0]                        hdr_ff;
   logic [15:0]                        si_ff;
   logic                               err_ff;
   logic [1:0]                         err_status_ff;
   logic [mafh_pkg::ALU_W-1:0]         rem_ff;
   logic [mafh_pkg::ALU_W-1:0]         dsh_ff;
   logic [mafh_pkg::QUOT_W-1:0]        quot_ff;
   logic [3:0]                         step_ff;
   logic [mafh_pkg::SIZE_W-1:0]        msize_ff;
   logic [mafh_pkg::MDB_W-1:0]         need_ff;
   logic                               covered_ff;
   logic [CW-1:0]                      cnt_ff;
   logic                               walked_ff;

   logic                               have_ref_ff;
   logic [1:0]                         ref_layer_ff;
   logic [1:0]                         ref_rate_ff;
   logic                               prev_two_ff;
   logic [5:0]                         prev_dep_ff;
   logic [47:0]                        time_ff;

   logic                               rsp_valid_ff;
   logic [1:0]                         status_ff;
   logic [10:0]                        bytes_ff;
   logic [10:0]                        samples_ff;
   logic [15:0]                        rate_ff;
   logic [1:0]                         chan_ff;
   logic [5:0]                         preroll_ff;
   logic [47:0]                        dtime_ff;

   logic                               ver;
   logic [1:0]                         layer;
   logic                               no_crc;
   logic [3:0]                         bri;
   logic [1:0]                         fsi;
   logic                               pad;
   logic                               two_ch;
   logic                               bad_c;
   logic                               unsup_c;
   logic [8:0]                         kbps_c;
   logic [15:0]                        freq_c;
   logic [17:0]                        factor_c;
   logic [mafh_pkg::ALU_W-1:0]         num_c;
   logic [16:0]                        div_c;
   logic [10:0]                        qp_c;
   logic [10:0]                        bytes_c;
   logic [10:0]                        samples_c;
   logic [5:0]                         side_c;
   logic [5:0]                         overhead_c;
   logic [mafh_pkg::MDB_W-1:0]         mdb_c;
   logic                               is_l3;
   logic [6:0]                         cnt_ext;
   logic [6:0]                         pre_ext;

   logic [mafh_pkg::ALU_W-1:0]         alu_a;
   logic [mafh_pkg::ALU_W-1:0]         alu_b;
   logic [mafh_pkg::ALU_W-1:0]         alu_diff;
   logic                               alu_borrow;

   logic [AW-1:0]                      rd_idx_c;
   logic [mafh_pkg::SIZE_W-1:0]        entry_c;
   logic                               push_c;
   logic                               out_free;

   assign ver    = hdr_ff[19];
   assign layer  = hdr_ff[18:17];
   assign no_crc = hdr_ff[16];
   assign bri    = hdr_ff[15:12];
   assign fsi    = hdr_ff[11:10];
   assign pad    = hdr_ff[9];
   assign two_ch = (hdr_ff[7:6] != mafh_pkg::MODE_SINGLE);
   assign is_l3  = (layer == mafh_pkg::LAYER_CODE_III);

   assign bad_c = (hdr_ff[31:20] != mafh_pkg::SYNC_WORD) ||
                  (layer == mafh_pkg::LAYER_CODE_NONE) ||
                  (bri == mafh_pkg::BRI_FREE) || (bri == mafh_pkg::BRI_BAD) ||
                  (fsi == mafh_pkg::RATE_RESERVED) ||
                  (hdr_ff[1:0] == mafh_pkg::EMPH_RESERVED);
   assign unsup_c = have_ref_ff && ((layer != ref_layer_ff) || (fsi != ref_rate_ff));

   assign kbps_c   = mafh_pkg::kbps_lookup(ver, layer, bri);
   assign freq_c   = mafh_pkg::rate_lookup(ver, fsi);
   assign factor_c = (layer == mafh_pkg::LAYER_CODE_I) ? mafh_pkg::SLOT_FACTOR_I
                                                       : mafh_pkg::SLOT_FACTOR_II;
   assign num_c    = mafh_pkg::ALU_W'(kbps_c) * mafh_pkg::ALU_W'(factor_c);
   assign div_c    = (is_l3 && !ver) ? {freq_c, 1'b0} : {1'b0, freq_c};

   assign qp_c      = quot_ff + 11'(pad);
   assign bytes_c   = (layer == mafh_pkg::LAYER_CODE_I) ? {qp_c[8:0], 2'b00} : qp_c;
   assign samples_c = (layer == mafh_pkg::LAYER_CODE_I) ? mafh_pkg::SAMPLES_I :
                      (ver || layer == mafh_pkg::LAYER_CODE_II) ? mafh_pkg::SAMPLES_FULL
                                                                : mafh_pkg::SAMPLES_HALF;
   assign side_c     = ver ? (two_ch ? 6'd32 : 6'd17) : (two_ch ? 6'd17 : 6'd9);
   assign overhead_c = side_c + (no_crc ? 6'd4 : 6'd6);
   assign mdb_c      = ver ? si_ff[15:7] : {1'b0, si_ff[15:8]};

   assign cnt_ext = 7'(cnt_ff);
   assign pre_ext = {1'b0, prev_dep_ff} + 7'd1;

   always_comb begin
      unique case (state_ff)
         ST_DIV: begin
            alu_a = rem_ff;
            alu_b = dsh_ff;
         end
         ST_SIZE: begin
            alu_a = mafh_pkg::ALU_W'(bytes_c);
            alu_b = mafh_pkg::ALU_W'(overhead_c);
         end
         ST_WALK: begin
            alu_a = mafh_pkg::ALU_W'(need_ff);
            alu_b = mafh_pkg::ALU_W'(entry_c);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   mafh_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign push_c   = (state_ff == ST_FINISH) && out_free && !err_ff && is_l3;
   assign rd_idx_c = (state_ff == ST_WALK) ? AW'(cnt_ff + 1'b1) : '0;

   mafh_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .AW            (AW)
   ) u_history (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx_c),
      .rd_data   (entry_c),
      .push      (push_c),
      .push_data (msize_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         have_ref_ff  <= 1'b0;
         ref_layer_ff <= '0;
         ref_rate_ff  <= '0;
         prev_two_ff  <= 1'b0;
         prev_dep_ff  <= '0;
         time_ff      <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  hdr_ff   <= req_header_word;
                  si_ff    <= req_side_info_bytes;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               err_ff        <= bad_c || unsup_c;
               err_status_ff <= bad_c ? mafh_pkg::STATUS_BAD_HEADER
                                      : mafh_pkg::STATUS_UNSUPPORTED;
               rem_ff        <= num_c;
               dsh_ff        <= mafh_pkg::ALU_W'(div_c) << (mafh_pkg::DIV_STEPS - 1);
               quot_ff       <= '0;
               step_ff       <= 4'(mafh_pkg::DIV_STEPS - 1);
               walked_ff     <= 1'b0;
               state_ff      <= (bad_c || unsup_c) ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
               quot_ff <= {quot_ff[mafh_pkg::QUOT_W-2:0], !alu_borrow};
               if (!alu_borrow) begin
                  rem_ff <= alu_diff;
               end
               dsh_ff  <= dsh_ff >> 1;
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= ST_SIZE;
               end
            end
            ST_SIZE: begin
               msize_ff   <= alu_borrow ? '0 : alu_diff[mafh_pkg::SIZE_W-1:0];
               need_ff    <= mdb_c;
               covered_ff <= 1'b0;
               cnt_ff     <= '0;
               if (is_l3 && mdb_c != '0) begin
                  walked_ff <= 1'b1;
                  state_ff  <= ST_WALK;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_WALK: begin
               if (covered_ff || cnt_ff == CW'(HISTORY_DEPTH) || entry_c == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  need_ff    <= alu_diff[mafh_pkg::MDB_W-1:0];
                  covered_ff <= alu_borrow || (alu_diff == '0);
                  cnt_ff     <= cnt_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  dtime_ff     <= time_ff;
                  state_ff     <= ST_IDLE;
                  if (err_ff) begin
                     status_ff  <= err_status_ff;
                     bytes_ff   <= '0;
                     samples_ff <= '0;
                     rate_ff    <= '0;
                     chan_ff    <= '0;
                     preroll_ff <= '0;
                  end else begin
                     status_ff  <= (have_ref_ff && two_ch != prev_two_ff)
                                   ? mafh_pkg::STATUS_CHAN_CHANGE : mafh_pkg::STATUS_OK;
                     bytes_ff   <= bytes_c;
                     samples_ff <= samples_c;
                     rate_ff    <= freq_c;
                     chan_ff    <= two_ch ? 2'd2 : 2'd1;
                     if (!is_l3) begin
                        preroll_ff <= '0;
                     end else if (walked_ff) begin
                        preroll_ff  <= (pre_ext > 7'(mafh_pkg::COUNT_MAX))
                                       ? mafh_pkg::COUNT_MAX : pre_ext[5:0];
                        prev_dep_ff <= (cnt_ext > 7'(mafh_pkg::COUNT_MAX))
                                       ? mafh_pkg::COUNT_MAX : cnt_ext[5:0];
                     end else begin
                        preroll_ff <= 6'd1;
                     end
                     time_ff      <= time_ff + 48'(samples_c);
                     have_ref_ff  <= 1'b1;
                     ref_layer_ff <= layer;
                     ref_rate_ff  <= fsi;
                     prev_two_ff  <= two_ch;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_frame_bytes       = bytes_ff;
   assign rsp_samples_per_frame = samples_ff;
   assign rsp_sample_rate_hz    = rate_ff;
   assign rsp_channel_count     = chan_ff;
   assign rsp_preroll_frames    = preroll_ff;
   assign rsp_decode_time       = dtime_ff;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the MPEG audio frame header tracker core: a table of
// directed frames and random frames with idling on both channels, checked by a tracker.
// Depends on mafh_pkg and mpeg_audio_frame_header_tracker_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH           = mafh_pkg::HISTORY_DEPTH_DEFAULT;
   localparam int DIRECTED_COUNT  = 20;
   localparam int RANDOM_ITEMS    = 1080;
   localparam int CALM_ITEMS      = 150;
   localparam int DRAIN_CYCLES    = 64;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;
   localparam logic [1:0] RATE_44K = 2'd0;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] frame_bytes;
      logic [10:0] samples;
      logic [15:0] rate_hz;
      logic [1:0]  channels;
      logic [5:0]  preroll;
      logic [47:0] decode_time;
   } frame_result_type;

   typedef struct packed {
      logic [31:0]      header;
      logic [15:0]      si_word;
      logic             typed;
      frame_result_type want;
   } stim_row_type;

   localparam frame_result_type NO_RESULT = '0;
   localparam frame_result_type BAD_AT_RESET =
      '{mafh_pkg::STATUS_BAD_HEADER, 11'd0, 11'd0, 16'd0, 2'd0, 6'd0, 48'd0};
   localparam frame_result_type FIRST_FRAME =
      '{mafh_pkg::STATUS_OK, 11'd417, 11'd1152, 16'd44100, 2'd2, 6'd1, 48'd0};
   localparam frame_result_type BAD_LATER =
      '{mafh_pkg::STATUS_BAD_HEADER, 11'd0, 11'd0, 16'd0, 2'd0, 6'd0, 48'd1152};
   localparam frame_result_type REFUSED_LATER =
      '{mafh_pkg::STATUS_UNSUPPORTED, 11'd0, 11'd0, 16'd0, 2'd0, 6'd0, 48'd1152};

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{32'h0000_0000, 16'h0000, 1'b1, BAD_AT_RESET},
      '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, BAD_AT_RESET},
      '{32'hFFEB_9000, 16'h0000, 1'b1, BAD_AT_RESET},
      '{32'hFFFB_9000, 16'h0000, 1'b1, FIRST_FRAME},
      '{32'hFFFD_9000, 16'h0000, 1'b1, REFUSED_LATER},
      '{32'hFFFF_9000, 16'h0000, 1'b1, REFUSED_LATER},
      '{32'hFFFB_9400, 16'h0000, 1'b1, REFUSED_LATER},
      '{32'hFFFB_9C00, 16'h0000, 1'b1, BAD_LATER},
      '{32'hFFFB_0000, 16'h0000, 1'b1, BAD_LATER},
      '{32'hFFFB_9002, 16'h0000, 1'b1, BAD_LATER},
      '{32'hFFF9_9000, 16'h0000, 1'b1, BAD_LATER},
      '{32'hFFFB_90C0, 16'h0000, 1'b0, NO_RESULT},
      '{32'hFFFA_90C0, 16'h8000, 1'b0, NO_RESULT},
      '{32'hFFFB_1200, 16'h0100, 1'b0, NO_RESULT},
      '{32'hFFFB_E37D, 16'hFFFF, 1'b0, NO_RESULT},
      '{32'hFFF3_E000, 16'hFFFF, 1'b0, NO_RESULT},
      '{32'hFFF3_10C3, 16'h0100, 1'b0, NO_RESULT},
      '{32'hFFFB_9001, 16'hFF80, 1'b0, NO_RESULT},
      '{32'hFFFB_9000, 16'h0080, 1'b0, NO_RESULT},
      '{32'hFFFA_9000, 16'h0000, 1'b0, NO_RESULT}
   };

   // Bitrates in kbit/s by version, layer code minus one and bitrate index.
   localparam int unsigned KBPS [2][3][16] = '{
      '{
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}
      },
      '{
         '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
         '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
      }
   };
   localparam int unsigned RATES [2][3] = '{
      '{22050, 24000, 16000},
      '{44100, 48000, 32000}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_header_word = '0;
   logic [15:0] req_side_info_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [10:0] rsp_frame_bytes;
   logic [10:0] rsp_samples_per_frame;
   logic [15:0] rsp_sample_rate_hz;
   logic [1:0]  rsp_channel_count;
   logic [5:0]  rsp_preroll_frames;
   logic [47:0] rsp_decode_time;

   mpeg_audio_frame_header_tracker_core i_dut (.*);

   // Tracker state.
   logic        have_ref = 1'b0;
   logic [1:0]  ref_layer = '0;
   logic [1:0]  ref_rate = '0;
   logic        prev_stereo = 1'b0;
   logic [10:0] main_data_sizes [DEPTH] = '{default: '0};
   logic [5:0]  prev_deps = '0;
   logic [47:0] sample_clock = '0;

   frame_result_type pending_results [$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;
   logic             idle_allowed = 1'b1;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic frame_result_type track_frame(input logic [31:0] hw,
                                                    input logic [15:0] si);
      frame_result_type res;
      logic          ver;
      logic [1:0]    layer;
      logic [3:0]    bri;
      logic [1:0]    fsi;
      logic          stereo;
      int unsigned   kbps, freq, bytes, overhead, mdb, sum, used, pre;
      int            k;
      ver   = hw[19];
      layer = hw[18:17];
      bri   = hw[15:12];
      fsi   = hw[11:10];
      res = '0;
      res.decode_time = sample_clock;
      if (hw[31:20] != mafh_pkg::SYNC_WORD || layer == mafh_pkg::LAYER_CODE_NONE ||
          bri == mafh_pkg::BRI_FREE || bri == mafh_pkg::BRI_BAD ||
          fsi == mafh_pkg::RATE_RESERVED || hw[1:0] == mafh_pkg::EMPH_RESERVED) begin
         res.status = mafh_pkg::STATUS_BAD_HEADER;
         return res;
      end
      if (have_ref && (layer != ref_layer || fsi != ref_rate)) begin
         res.status = mafh_pkg::STATUS_UNSUPPORTED;
         return res;
      end
      kbps = KBPS[ver][int'(layer) - 1][bri];
      freq = RATES[ver][fsi];
      if (layer == mafh_pkg::LAYER_CODE_I) begin
         bytes = (12000 * kbps / freq + hw[9]) * 4;
         res.samples = mafh_pkg::SAMPLES_I;
      end else begin
         bytes = 144000 * kbps /
                 ((layer == mafh_pkg::LAYER_CODE_III && !ver) ? 2 * freq : freq) + hw[9];
         res.samples = (ver || layer == mafh_pkg::LAYER_CODE_II) ? mafh_pkg::SAMPLES_FULL
                                                                 : mafh_pkg::SAMPLES_HALF;
      end
      stereo = (hw[7:6] != mafh_pkg::MODE_SINGLE);
      res.status = (have_ref && stereo != prev_stereo) ? mafh_pkg::STATUS_CHAN_CHANGE
                                                       : mafh_pkg::STATUS_OK;
      pre = 0;
      if (layer == mafh_pkg::LAYER_CODE_III) begin
         overhead = (hw[16] ? 4 : 6) + (ver ? (stereo ? 32 : 17) : (stereo ? 17 : 9));
         mdb = ver ? si[15:7] : si[15:8];
         pre = 1;
         if (mdb != 0) begin
            sum = 0;
            used = 0;
            while (used < DEPTH && sum < mdb) begin
               sum += main_data_sizes[used];
               if (main_data_sizes[used] == 0) break;
               used++;
            end
            pre = (1 + prev_deps > 63) ? 63 : 1 + prev_deps;
            prev_deps = (used > 63) ? 6'd63 : 6'(used);
         end
         for (k = DEPTH - 1; k > 0; k--) main_data_sizes[k] = main_data_sizes[k - 1];
         main_data_sizes[0] = (bytes > overhead) ? 11'(bytes - overhead) : 11'd0;
      end
      res.frame_bytes = 11'(bytes);
      res.rate_hz     = 16'(freq);
      res.channels    = stereo ? 2'd2 : 2'd1;
      res.preroll     = 6'(pre);
      sample_clock    = sample_clock + res.samples;
      have_ref    = 1'b1;
      ref_layer   = layer;
      ref_rate    = fsi;
      prev_stereo = stereo;
      return res;
   endfunction

   function automatic string fmt_result(input frame_result_type r);
      return $sformatf("st=%0d bytes=%0d spf=%0d hz=%0d ch=%0d pre=%0d t=%0d", r.status,
                       r.frame_bytes, r.samples, r.rate_hz, r.channels, r.preroll,
                       r.decode_time);
   endfunction

   function automatic void flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   task automatic send_frame(input logic [31:0] hw, input logic [15:0] si, input logic typed,
                             input frame_result_type typed_want);
      frame_result_type predicted;
      int               gap;
      gap = (idle_allowed && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_header_word     <= hw;
      req_side_info_bytes <= si;
      do @(posedge clock); while (req_stall);
      predicted = track_frame(hw, si);
      pending_results.push_back(typed ? typed_want : predicted);
   endtask

   initial begin : stimulus
      stim_row_type row;
      logic [31:0]  hw;
      logic [15:0]  si;
      int           n;
      int           kind;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (n = 0; n < DIRECTED_COUNT; n++) begin
         row = DIRECTED_ROWS[n];
         send_frame(row.header, row.si_word, row.typed, row.want);
      end
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         idle_allowed = ((n / 64) % 3 != 2) && (n < RANDOM_ITEMS - CALM_ITEMS);
         kind = $urandom_range(0, 99);
         hw = $urandom;
         si = 16'($urandom);
         if (kind < 82) begin
            hw[31:20] = mafh_pkg::SYNC_WORD;
            hw[18:17] = mafh_pkg::LAYER_CODE_III;
            hw[11:10] = RATE_44K;
            hw[15:12] = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 3))
                                                    : 4'($urandom_range(1, 14));
            if (hw[1:0] == mafh_pkg::EMPH_RESERVED) hw[1:0] = 2'd0;
            if ($urandom_range(0, 3) == 0) si[15:7] = '0;
            else if ($urandom_range(0, 1) == 0) si[15:12] = '0;
         end else if (kind < 92) begin
            hw[31:20] = mafh_pkg::SYNC_WORD;
         end
         send_frame(hw, si, 1'b0, NO_RESULT);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatch_count == 0) begin
         $display("** mpeg_audio_frame_header_tracker_core: PASSED **");
      end else begin
         $display("** mpeg_audio_frame_header_tracker_core: FAILED **");
      end
      $finish;
   end

   initial begin : response_side
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (!idle_allowed) burst = 0;
         if (burst == 0 && idle_allowed && $urandom_range(0, 7) == 0)
            burst = $urandom_range(1, 10);
         if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_frame_bytes, rsp_samples_per_frame, rsp_sample_rate_hz,
                 rsp_channel_count, rsp_preroll_frames, rsp_decode_time};
         if (pending_results.size() == 0) begin
            flag_error({"unexpected transfer: ", fmt_result(got)});
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               flag_error({"expected ", fmt_result(want), " got ", fmt_result(got)});
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** mpeg_audio_frame_header_tracker_core: FAILED **");
      $finish;
   end

endmodule

FILE: mpeg_audio_frame_header_tracker_core.f
rtl/mafh_pkg.sv
rtl/mafh_alu.sv
rtl/mafh_history.sv
rtl/mpeg_audio_frame_header_tracker_core.sv
dv/testbench.sv
